// File: hdl/tccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // operation codes
  localparam logic [2:0] FUNC_PUT_CHAR  = 3'd0;
  localparam logic [2:0] FUNC_BACKSPACE = 3'd1;
  localparam logic [2:0] FUNC_SET_CUR   = 3'd2;
  localparam logic [2:0] FUNC_DIRECT    = 3'd3;
  localparam logic [2:0] FUNC_CLEAR     = 3'd4;
  localparam logic [2:0] FUNC_READ      = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_TEXT_FG      = 3'd0;
  localparam logic [2:0] CFG_TEXT_BG      = 3'd1;
  localparam logic [2:0] CFG_TEXT_BLINK   = 3'd2;
  localparam logic [2:0] CFG_CURSOR_FG    = 3'd3;
  localparam logic [2:0] CFG_CURSOR_BG    = 3'd4;
  localparam logic [2:0] CFG_CURSOR_BLINK = 3'd5;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  char_code;
    logic [11:0] target_pos;
    logic [6:0]  column;
    logic [4:0]  row;
    logic [3:0]  cell_fg;
    logic [3:0]  cell_bg;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [10:0] cursor_position;
    logic [10:0] write_position;
    logic [15:0] cell_value;
  } out_t;

endpackage
`default_nettype wire

// File: hdl/tccw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_ram
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/text_console_cell_writer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Text console: cell store plus a sequencer driving its single RAM port pair.
// ----------------------------------------------------------------------------
// Reads and direct writes pass a wait state; off-screen reads and unused codes go
// straight to done. Put char and newline end by marking the cursor cell; set cursor
// and backspace do so too unless rejected; backspace at a row start does nothing. A
// scroll copies each row up and zeroes the last row; clear and home zeroes every
// cell. busy falls the cycle after done; no item is taken before then. Reset clears
// the screen with busy high. Each result is strobed on done for one cycle; no stall.
module text_console_cell_writer_top #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire tccw_pkg::in_t cmd,
  output logic               busy,
  output logic               done,
  output tccw_pkg::out_t     result,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [3:0]    cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int TW    = (PW > 12) ? PW : 12;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLR     = 4'd1;
  localparam logic [3:0] S_NL2     = 4'd2;
  localparam logic [3:0] S_CHK     = 4'd3;
  localparam logic [3:0] S_SC_RD   = 4'd4;
  localparam logic [3:0] S_SC_WR   = 4'd5;
  localparam logic [3:0] S_SC_ZERO = 4'd6;
  localparam logic [3:0] S_CLAMP   = 4'd7;
  localparam logic [3:0] S_MK_RD   = 4'd8;
  localparam logic [3:0] S_MK_WR   = 4'd9;
  localparam logic [3:0] S_CUR_RD  = 4'd10;
  localparam logic [3:0] S_CUR_WR  = 4'd11;
  localparam logic [3:0] S_DW      = 4'd12;
  localparam logic [3:0] S_RD_WAIT = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0]    state;
  logic          clr_boot;
  logic [PW-1:0] wp;
  logic [PW-1:0] cur;
  logic [CW-1:0] wcol;
  logic [PW-1:0] ptr;
  logic [TW-1:0] tpos;
  logic          tvalid;
  logic          status;
  logic [15:0]   value;
  logic [AW-1:0] dw_addr;
  logic [15:0]   dw_data;
  logic          dw_ok;

  logic [3:0] text_fg, cursor_fg;
  logic [2:0] text_bg, cursor_bg;
  logic       text_blink, cursor_blink;
  logic [7:0] tattr, kattr;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  assign tattr = {text_blink, text_bg, text_fg};
  assign kattr = {cursor_blink, cursor_bg, cursor_fg};

  tccw_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_fg      <= '0;
      text_bg      <= '0;
      text_blink   <= 1'b0;
      cursor_fg    <= '0;
      cursor_bg    <= '0;
      cursor_blink <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tccw_pkg::CFG_TEXT_FG:      text_fg      <= cfg_data;
        tccw_pkg::CFG_TEXT_BG:      text_bg      <= cfg_data[2:0];
        tccw_pkg::CFG_TEXT_BLINK:   text_blink   <= cfg_data[0];
        tccw_pkg::CFG_CURSOR_FG:    cursor_fg    <= cfg_data;
        tccw_pkg::CFG_CURSOR_BG:    cursor_bg    <= cfg_data[2:0];
        tccw_pkg::CFG_CURSOR_BLINK: cursor_blink <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // RAM port usage per state
  always_comb begin
    we    = 1'b0;
    waddr = wp[AW-1:0];
    wdata = '0;
    re    = 1'b0;
    raddr = cur[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd.func)
            tccw_pkg::FUNC_PUT_CHAR: begin
              we    = 1'b1;
              wdata = (cmd.char_code == tccw_pkg::NEWLINE_CODE) ?
                      {tattr, 8'h00} : {tattr, cmd.char_code};
            end
            tccw_pkg::FUNC_BACKSPACE: begin
              we    = (wcol != '0);
              waddr = AW'(wp - PW'(1));
              wdata = {tattr, 8'h00};
            end
            tccw_pkg::FUNC_READ: begin
              re    = (TW'(cmd.target_pos) < TW'(CELLS));
              raddr = AW'(cmd.target_pos);
            end
            default: ;
          endcase
        end
      end
      S_CLR, S_SC_ZERO: begin
        we    = 1'b1;
        waddr = ptr[AW-1:0];
      end
      S_NL2: begin
        we    = 1'b1;
        waddr = cur[AW-1:0];
        wdata = {tattr, 8'h00};
      end
      S_SC_RD: begin
        re    = 1'b1;
        raddr = AW'(ptr + PW'(COLUMNS));
      end
      S_SC_WR: begin
        we    = 1'b1;
        waddr = ptr[AW-1:0];
        wdata = rdata;
      end
      S_MK_RD, S_CUR_RD: re = 1'b1;
      S_MK_WR: begin
        we    = 1'b1;
        waddr = cur[AW-1:0];
        wdata = rdata | {kattr, 8'h00};
      end
      S_CUR_WR: begin
        we    = 1'b1;
        waddr = cur[AW-1:0];
        wdata = {tattr, rdata[7:0]};
      end
      S_DW: begin
        we    = dw_ok;
        waddr = dw_addr;
        wdata = dw_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_boot <= 1'b1;
      ptr      <= '0;
      wp       <= '0;
      cur      <= '0;
      wcol     <= '0;
      status   <= 1'b0;
      value    <= '0;
      tvalid   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            status <= 1'b0;
            value  <= '0;
            unique case (cmd.func)
              tccw_pkg::FUNC_PUT_CHAR: begin
                if (cmd.char_code == tccw_pkg::NEWLINE_CODE) begin
                  state <= S_NL2;
                end else begin
                  wp    <= wp + PW'(1);
                  cur   <= cur + PW'(1);
                  wcol  <= (wcol == CW'(COLUMNS - 1)) ? '0 : wcol + CW'(1);
                  state <= S_CHK;
                end
              end
              tccw_pkg::FUNC_BACKSPACE: begin
                if (wcol != '0) begin
                  wp     <= wp - PW'(1);
                  wcol   <= wcol - CW'(1);
                  tpos   <= TW'(cur - PW'(1));
                  tvalid <= (cur != '0);
                  state  <= S_CUR_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              tccw_pkg::FUNC_SET_CUR: begin
                tpos   <= TW'(cmd.target_pos);
                tvalid <= 1'b1;
                state  <= S_CUR_RD;
              end
              tccw_pkg::FUNC_DIRECT: begin
                dw_ok   <= (int'(cmd.column) < COLUMNS) && (int'(cmd.row) < ROWS);
                dw_addr <= AW'(int'(cmd.row) * COLUMNS + int'(cmd.column));
                dw_data <= {cmd.cell_bg, cmd.cell_fg, cmd.char_code};
                state   <= S_DW;
              end
              tccw_pkg::FUNC_CLEAR: begin
                ptr      <= '0;
                wp       <= '0;
                cur      <= '0;
                wcol     <= '0;
                clr_boot <= 1'b0;
                state    <= S_CLR;
              end
              tccw_pkg::FUNC_READ: begin
                state <= (TW'(cmd.target_pos) < TW'(CELLS)) ? S_RD_WAIT : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_CLR: begin
          ptr <= ptr + PW'(1);
          if (ptr == PW'(CELLS - 1)) begin
            state <= clr_boot ? S_IDLE : S_DONE;
          end
        end
        S_NL2: begin
          wp    <= wp + PW'(COLUMNS) - PW'(wcol);
          cur   <= wp + PW'(COLUMNS) - PW'(wcol);
          wcol  <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          ptr   <= '0;
          state <= (wp >= PW'(CELLS)) ? S_SC_RD : S_CLAMP;
        end
        S_SC_RD: state <= S_SC_WR;
        S_SC_WR: begin
          ptr   <= ptr + PW'(1);
          state <= (ptr == PW'(CELLS - COLUMNS - 1)) ? S_SC_ZERO : S_SC_RD;
        end
        S_SC_ZERO: begin
          ptr <= ptr + PW'(1);
          if (ptr == PW'(CELLS - 1)) begin
            wp    <= wp - PW'(COLUMNS);
            cur   <= (cur >= PW'(COLUMNS)) ? cur - PW'(COLUMNS) : '0;
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (cur >= PW'(CELLS)) begin
            cur <= PW'(CELLS - 1);
          end
          state <= S_MK_RD;
        end
        S_MK_RD:  state <= S_MK_WR;
        S_MK_WR:  state <= S_DONE;
        S_CUR_RD: state <= S_CUR_WR;
        S_CUR_WR: begin
          if (tvalid && (tpos < TW'(CELLS))) begin
            cur   <= PW'(tpos);
            state <= S_MK_RD;
          end else begin
            status <= 1'b1;
            state  <= S_DONE;
          end
        end
        S_DW: state <= S_DONE;
        S_RD_WAIT: begin
          value <= rdata;
          state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy                   = (state != S_IDLE);
  assign done                   = (state == S_DONE);
  assign result.status          = status;
  assign result.cursor_position = 11'(cur);
  assign result.write_position  = 11'(wp);
  assign result.cell_value      = value;

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cur < PW'(CELLS)))
    else $error("cursor outside screen while idle");

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (wp < PW'(CELLS)))
    else $error("write position outside screen while idle");

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (int'(waddr) < CELLS))
    else $error("cell write outside screen");

endmodule
`default_nettype wire
